FILE: rtl/bf_pkg.sv
// Shared types, constants and weight tables for the grayscale bilateral filter.
// Depends on nothing; imported by bf_datapath, bf_ctrl and the top level.
package bf_pkg;

   localparam int RADIUS_DEF     = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int SIGMA_SPACE    = 13;
   localparam int SIGMA_GREY     = 13;
   localparam int WFRAC          = 16;

   localparam int REG_W          = 11;
   localparam int PIX_W          = 8;
   localparam int ROW_W          = 10;
   localparam int XW             = 13;
   localparam int YW             = 12;
   localparam int DXW            = 4;
   localparam int D2W            = 7;
   localparam int SPACE_SIZE     = 99;
   localparam int GREY_SIZE      = 256;
   localparam int WEIGHT_W       = WFRAC + 1;
   localparam int PROD_W         = 2 * WEIGHT_W;
   localparam int WG_W           = WEIGHT_W + PIX_W;
   localparam int NUM_W          = 32;
   localparam int DEN_W          = 24;
   localparam int CNT_W          = 5;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic REG_IDX_WIDTH  = 1'b0;
   localparam logic REG_IDX_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
   localparam logic [63:0] SPACE_DIV = 64'(2 * SIGMA_SPACE * SIGMA_SPACE);
   localparam logic [63:0] GREY_DIV  = 64'(2 * SIGMA_GREY * SIGMA_GREY);

   typedef struct packed {
      logic                  accept_pixel;
      logic                  load_center;
      logic                  tap_issue;
      logic                  row_end;
      logic signed [DXW-1:0] dx;
      logic signed [DXW-1:0] dy;
      logic                  div_load;
      logic                  div_step;
      logic                  finish;
   } bf_cmd_type;

   typedef struct packed {
      logic pixel_emits;
      logic pending_nonzero;
      logic out_free;
   } bf_status_type;

   typedef logic [SPACE_SIZE-1:0][WEIGHT_W-1:0] space_tab_type;
   typedef logic [GREY_SIZE-1:0][WEIGHT_W-1:0]  grey_tab_type;

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 32;
   endfunction

   // exp(-f) for f in [0,1) as Q32, truncated Taylor series
   function automatic logic [63:0] exp_frac(logic [63:0] f);
      logic [63:0] t;
      longint      s;
      t = ONE_Q32;
      s = longint'(ONE_Q32);
      t = qmul(t, f) / 64'd1;   s = s - longint'(t);
      t = qmul(t, f) / 64'd2;   s = s + longint'(t);
      t = qmul(t, f) / 64'd3;   s = s - longint'(t);
      t = qmul(t, f) / 64'd4;   s = s + longint'(t);
      t = qmul(t, f) / 64'd5;   s = s - longint'(t);
      t = qmul(t, f) / 64'd6;   s = s + longint'(t);
      t = qmul(t, f) / 64'd7;   s = s - longint'(t);
      t = qmul(t, f) / 64'd8;   s = s + longint'(t);
      t = qmul(t, f) / 64'd9;   s = s - longint'(t);
      t = qmul(t, f) / 64'd10;  s = s + longint'(t);
      t = qmul(t, f) / 64'd11;  s = s - longint'(t);
      t = qmul(t, f) / 64'd12;  s = s + longint'(t);
      t = qmul(t, f) / 64'd13;  s = s - longint'(t);
      t = qmul(t, f) / 64'd14;  s = s + longint'(t);
      t = qmul(t, f) / 64'd15;  s = s - longint'(t);
      t = qmul(t, f) / 64'd16;  s = s + longint'(t);
      if (s < 0) s = 0;
      return 64'(s);
   endfunction

   // exp(-d / divisor) as Q1.WFRAC, rounded; grey selects the range divisor
   function automatic logic [WEIGHT_W-1:0] gauss_q(logic [63:0] d, logic grey);
      logic [63:0] q;
      logic [63:0] n;
      logic [63:0] half;
      logic [63:0] em1;
      logic [63:0] v;
      q    = grey ? (d << 32) / GREY_DIV : (d << 32) / SPACE_DIV;
      n    = q >> 32;
      half = exp_frac(ONE_Q32 >> 1);
      em1  = qmul(half, half);
      if (n >= 64'd32) return '0;
      v = exp_frac(q & (ONE_Q32 - 64'd1));
      for (int i = 0; i < 32; i++) begin
         if (64'(i) < n) v = qmul(v, em1);
      end
      v = (v + (64'd1 << (31 - WFRAC))) >> (32 - WFRAC);
      return v[WEIGHT_W-1:0];
   endfunction

   function automatic space_tab_type make_space_tab();
      space_tab_type t;
      for (int i = 0; i < SPACE_SIZE; i++) t[i] = gauss_q(64'(i), 1'b0);
      return t;
   endfunction

   function automatic grey_tab_type make_grey_tab();
      grey_tab_type t;
      for (int i = 0; i < GREY_SIZE; i++) t[i] = gauss_q(64'(i) * 64'(i), 1'b1);
      return t;
   endfunction

   localparam space_tab_type SPACE_W = make_space_tab();
   localparam grey_tab_type  GREY_W  = make_grey_tab();

endpackage

FILE: rtl/bf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the line store.
module bf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bf_datapath.sv
// Datapath of the bilateral filter: line store, tap addressing, weight pipeline,
// accumulators, restoring divider and result register. Uses bf_pkg and bf_ram.
module bf_datapath import bf_pkg::*; #(
   parameter int RADIUS    = RADIUS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_restart,
   input  logic [REG_W-1:0] width_reg,
   input  logic [REG_W-1:0] height_reg,
   input  logic [PIX_W-1:0] pixel,
   input  bf_cmd_type       cmd,
   output bf_status_type    status,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int DEPTH = (2 * RADIUS + 1) * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = AW + 1;
   localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

   function automatic logic [AW-1:0] add_mod(logic [AW-1:0] a, logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] sub_mod(logic [AW-1:0] a, logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + DEPTH_X - {1'b0, b};
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[AW-1:0];
   endfunction

   logic [REG_W-1:0] eff_w, eff_h;
   logic [AW-1:0]    w_aw, lag, jump, center_addr, start_addr, rd_addr;
   logic [AW:0]      jump_sum;

   always_comb begin
      if (width_reg == '0)                eff_w = REG_W'(1);
      else if (int'(width_reg) > MAX_WIDTH) eff_w = REG_W'(MAX_WIDTH);
      else                                eff_w = width_reg;
      if (height_reg == '0)                 eff_h = REG_W'(1);
      else if (int'(height_reg) > MAX_HEIGHT) eff_h = REG_W'(MAX_HEIGHT);
      else                                  eff_h = height_reg;
      w_aw     = AW'(eff_w);
      lag      = AW'(RADIUS * int'(eff_w) + RADIUS);
      jump_sum = {1'b0, w_aw} + DEPTH_X - (AW+1)'(2 * RADIUS);
      if (jump_sum >= DEPTH_X) jump_sum = jump_sum - DEPTH_X;
      jump = jump_sum[AW-1:0];
   end

   // write pointer, pending count, output position
   logic [AW-1:0]    wp_ff, wp_in, pending_ff, pending_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [REG_W-1:0] out_col_ff, out_col_in;
   logic             frame_end;

   assign center_addr = sub_mod(wp_ff, pending_ff);
   assign start_addr  = sub_mod(center_addr, lag);
   assign frame_end   = ({1'b0, out_row_ff} == eff_h - REG_W'(1)) &&
                        (out_col_ff == eff_w - REG_W'(1));

   always_comb begin
      wp_in      = wp_ff;
      pending_in = pending_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (cmd.accept_pixel) begin
         wp_in      = add_mod(wp_ff, AW'(1));
         pending_in = pending_ff + AW'(1);
      end
      if (cmd.finish) begin
         pending_in = pending_ff - AW'(1);
         if (out_col_ff + REG_W'(1) >= eff_w) begin
            out_col_in = '0;
            if ({1'b0, out_row_ff} + REG_W'(1) >= eff_h) out_row_in = '0;
            else out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + REG_W'(1);
         end
      end
      if (cfg_restart) begin
         wp_in      = '0;
         pending_in = '0;
         out_row_in = '0;
         out_col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         pending_ff <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         wp_ff      <= wp_in;
         pending_ff <= pending_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // tap walker
   logic [AW-1:0]        tap_addr_ff;
   logic signed [OW-1:0] tap_off_ff;
   logic signed [XW-1:0] tap_x_ff, tap_x_start;
   logic signed [YW-1:0] tap_y_ff;
   logic                 v0;
   logic signed [7:0]    dx8, dy8;
   logic [D2W-1:0]       d2_0;

   assign tap_x_start = $signed({2'b00, out_col_ff}) - $signed(XW'(RADIUS));

   always_ff @(posedge clock) begin
      if (cmd.load_center) begin
         tap_addr_ff <= start_addr;
         tap_off_ff  <= -$signed({1'b0, lag});
         tap_x_ff    <= tap_x_start;
         tap_y_ff    <= $signed({2'b00, out_row_ff}) - $signed(YW'(RADIUS));
      end else if (cmd.tap_issue) begin
         if (cmd.row_end) begin
            tap_addr_ff <= add_mod(tap_addr_ff, jump);
            tap_off_ff  <= tap_off_ff + $signed({1'b0, w_aw}) - $signed(OW'(2 * RADIUS));
            tap_x_ff    <= tap_x_start;
            tap_y_ff    <= tap_y_ff + $signed(YW'(1));
         end else begin
            tap_addr_ff <= add_mod(tap_addr_ff, AW'(1));
            tap_off_ff  <= tap_off_ff + $signed(OW'(1));
            tap_x_ff    <= tap_x_ff + $signed(XW'(1));
         end
      end
   end

   assign v0 = cmd.tap_issue && !tap_y_ff[YW-1] && (tap_y_ff < $signed({1'b0, eff_h})) &&
               !tap_x_ff[XW-1] && (tap_x_ff < $signed({2'b00, eff_w})) &&
               (tap_off_ff < $signed({1'b0, pending_ff}));
   assign dx8  = 8'(cmd.dx);
   assign dy8  = 8'(cmd.dy);
   assign d2_0 = D2W'(dx8 * dx8 + dy8 * dy8);

   assign rd_addr = cmd.load_center ? center_addr : tap_addr_ff;

   logic [PIX_W-1:0] rd_data;

   bf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
      .clock  (clock),
      .wr_en  (cmd.accept_pixel),
      .wr_addr(wp_ff),
      .wr_data(pixel),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // weight pipeline
   logic                v1_ff, c1_ff, v2_ff, v3_ff;
   logic [D2W-1:0]      d2_1_ff;
   logic [PIX_W-1:0]    g0_ff, g2_ff, diff;
   logic [PROD_W-1:0]   prod2_ff;
   logic [WEIGHT_W-1:0] w3, w3_ff;
   logic [WG_W-1:0]     wg3_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]    den_ff;

   assign diff = (rd_data > g0_ff) ? rd_data - g0_ff : g0_ff - rd_data;
   assign w3   = prod2_ff[WFRAC +: WEIGHT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         c1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v0;
         c1_ff <= cmd.load_center;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d2_1_ff  <= d2_0;
      if (c1_ff) g0_ff <= rd_data;
      prod2_ff <= PROD_W'(SPACE_W[d2_1_ff]) * PROD_W'(GREY_W[diff]);
      g2_ff    <= rd_data;
      w3_ff    <= w3;
      wg3_ff   <= WG_W'(w3) * WG_W'(g2_ff);
      if (cmd.load_center) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (v3_ff) begin
         num_ff <= num_ff + NUM_W'(wg3_ff);
         den_ff <= den_ff + DEN_W'(w3_ff);
      end
   end

   // restoring divider, one quotient bit per step
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W:0]   trial;
   logic             qbit;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign qbit  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= '0;
         quot_ff <= num_ff;
      end else if (cmd.div_step) begin
         rem_ff  <= qbit ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quot_ff <= {quot_ff[NUM_W-2:0], qbit};
      end
   end

   // result register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff, result;
   logic             rsp_last_ff;

   always_comb begin
      if (den_ff == '0)                     result = '0;
      else if (quot_ff > NUM_W'(255))       result = PIX_W'(255);
      else                                  result = quot_ff[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_data_ff <= result;
         rsp_last_ff <= frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.pixel_emits     = pending_ff >= lag;
   assign status.pending_nonzero = pending_ff != '0;
   assign status.out_free        = !rsp_valid_ff || rsp_tready;

   // center tap always counts, so the denominator is never empty
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> den_ff != '0) else $error("empty weight sum at finish");

   // weighted average of 8-bit values never exceeds 255
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> quot_ff <= NUM_W'(255)) else $error("quotient out of range");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_pixel |-> pending_ff <= lag) else $error("pending count past lag");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish)) else $error("result without finish");

endmodule

FILE: rtl/bf_ctrl.sv
// Sequencer of the bilateral filter: request intake, tap walk, drain, divide, hand-off.
// Uses bf_pkg; drives bf_datapath through bf_cmd_type.
module bf_ctrl import bf_pkg::*; #(
   parameter int RADIUS = RADIUS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_op,
   output logic          req_tready,
   input  bf_status_type status,
   output bf_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CENTER = 3'd1;
   localparam logic [2:0] ST_TAPS   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic signed [DXW-1:0] DX_LO = -$signed(DXW'(RADIUS));
   localparam logic signed [DXW-1:0] DX_HI = $signed(DXW'(RADIUS));
   localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(3);
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(NUM_W - 1);

   logic [2:0]            state_ff, state_in;
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.dx   = dx_ff;
      cmd.dy   = dy_ff;
      cmd.row_end = dx_ff == DX_HI;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_PIXEL) begin
                  cmd.accept_pixel = 1'b1;
                  if (status.pixel_emits) state_in = ST_CENTER;
               end else if (status.pending_nonzero) begin
                  state_in = ST_CENTER;
               end
            end
         end
         ST_CENTER: begin
            cmd.load_center = 1'b1;
            dx_in    = DX_LO;
            dy_in    = DX_LO;
            state_in = ST_TAPS;
         end
         ST_TAPS: begin
            cmd.tap_issue = 1'b1;
            if (dx_ff == DX_HI) begin
               dx_in = DX_LO;
               if (dy_ff == DX_HI) begin
                  cnt_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  dy_in = dy_ff + DXW'(1);
               end
            end else begin
               dx_in = dx_ff + DXW'(1);
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DRAIN_LAST) begin
               cmd.div_load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dx_ff    <= DX_LO;
         dy_ff    <= DX_LO;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/grayscale_bilateral_filter.sv
// Top level of the 15x15 grayscale bilateral filter: stream ports, register file.
// Uses bf_pkg, bf_ctrl and bf_datapath (which holds the bf_ram line store).
//
// Pixels enter in raster order on the req stream (tuser 0 = pixel, 1 = flush) and
// filtered pixels leave on the rsp stream, RADIUS*width+RADIUS positions behind
// the input; tlast marks the bottom-right pixel of the frame. A flush request
// releases the oldest pending result, or nothing when none is pending. A pixel
// request that produces no result leaves the intake ready. A request that produces a
// result holds the intake for the accepting step, a setup state that reads the center
// pixel, (2*RADIUS+1)^2 window taps at one tap per cycle through the single read port
// of the line store, a drain of the weight pipeline and 32 steps of the restoring
// divider, then a hand-off of the result to the output register; the hand-off waits
// for as long as the previous result still waits there unaccepted. The next request
// is taken while a finished result still waits there. The line store needs no
// clearing pass after reset. Write image_width (byte address 0) or image_height
// (byte address 4) only while the block is idle; a write restarts the frame and
// drops pending results.
module grayscale_bilateral_filter import bf_pkg::*; #(
   parameter int RADIUS    = RADIUS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel_value
   input  logic        req_tuser,    // [0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] filtered_value
   output logic        rsp_tlast,    // frame_end
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [REG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic             cfg_write;
   bf_cmd_type       cmd;
   bf_status_type    status;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   // hold the size registers; a write to either one restarts the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         case (csr_paddr[2])
            REG_IDX_WIDTH:  width_in  = csr_pwdata[REG_W-1:0];
            REG_IDX_HEIGHT: height_in = csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_IDX_WIDTH:  csr_prdata = {{(32-REG_W){1'b0}}, width_ff};
         REG_IDX_HEIGHT: csr_prdata = {{(32-REG_W){1'b0}}, height_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer: intake only while idle, then walk the window and divide
   bf_ctrl #(.RADIUS(RADIUS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_op    (req_tuser),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // line store, weighting, accumulation, divider and output register
   bf_datapath #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg_restart(cfg_write),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .pixel      (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
